[rtl/core/tecs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tecs_pkg;

    // Field and register widths.
    localparam int RAW_W      = 16;
    localparam int SIZE_CFG_W = 13;
    localparam int VALUE_W    = 32;
    localparam int TYPE_W     = 16;
    localparam int CODE_W     = 16;
    localparam int OUT_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int COORD_BITS_DEF = 12;

    // Event classes and codes.
    localparam logic [TYPE_W-1:0] EV_SYNC   = 16'd0;
    localparam logic [TYPE_W-1:0] EV_KEY    = 16'd1;
    localparam logic [TYPE_W-1:0] EV_ABS    = 16'd3;
    localparam logic [CODE_W-1:0] AXIS_Y    = 16'd0;
    localparam logic [CODE_W-1:0] AXIS_X    = 16'd1;
    localparam logic [CODE_W-1:0] KEY_TOUCH = 16'd330;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RAW_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_RAW_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd5;

    // Register reset values.
    localparam logic [RAW_W-1:0]      X_RAW_LOW_RST     = 16'd0;
    localparam logic [RAW_W-1:0]      X_RAW_HIGH_RST    = 16'd240;
    localparam logic [RAW_W-1:0]      Y_RAW_LOW_RST     = 16'd0;
    localparam logic [RAW_W-1:0]      Y_RAW_HIGH_RST    = 16'd320;
    localparam logic [SIZE_CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd240;
    localparam logic [SIZE_CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd320;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } tecs_state_t;

endpackage

`default_nettype wire

[rtl/core/tecs_event_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tecs_event_if;

    logic                            valid;
    logic                            ready;
    logic [tecs_pkg::TYPE_W-1:0]     event_type;
    logic [tecs_pkg::CODE_W-1:0]     event_code;
    logic signed [tecs_pkg::VALUE_W-1:0] event_value;

    modport source (
        output valid,
        output event_type,
        output event_code,
        output event_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  event_type,
        input  event_code,
        input  event_value,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/tecs_point_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tecs_point_if;

    logic                       valid;
    logic                       ready;
    logic [tecs_pkg::OUT_W-1:0] point_x;
    logic [tecs_pkg::OUT_W-1:0] point_y;

    modport source (
        output valid,
        output point_x,
        output point_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  point_x,
        input  point_y,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/tecs_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shift-and-add multiplier that consumes one multiplier bit per cycle, MSB first.
module tecs_serial_mul #(
    parameter int COORD_BITS = tecs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic [COORD_BITS:0]                     multiplicand,
    input  wire logic [tecs_pkg::RAW_W-1:0]              multiplier,
    output logic                                         done,
    output logic [tecs_pkg::RAW_W+COORD_BITS:0]          product
);

    localparam int PROD_W = tecs_pkg::RAW_W + COORD_BITS + 1;
    localparam int CNT_W  = $clog2(tecs_pkg::RAW_W + 1);

    logic [PROD_W-1:0]         acc_reg, acc_next;
    logic [COORD_BITS:0]       mcand_reg;
    logic [tecs_pkg::RAW_W-1:0] mplier_reg, mplier_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mplier_next = multiplier;
            cnt_next    = CNT_W'(tecs_pkg::RAW_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = {acc_reg[PROD_W-2:0], 1'b0}
                     + (mplier_reg[tecs_pkg::RAW_W-1] ? PROD_W'(mcand_reg) : '0);
            mplier_next = {mplier_reg[tecs_pkg::RAW_W-2:0], 1'b0};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mplier_reg <= mplier_next;
        if (start)
        begin
            mcand_reg <= multiplicand;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

[rtl/core/tecs_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider that produces one quotient bit per cycle. The caller
// guarantees that the quotient fits in COORD_BITS bits, so the upper part of
// the numerator is already below the divisor and seeds the remainder.
module tecs_serial_div #(
    parameter int COORD_BITS = tecs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    input  wire logic [tecs_pkg::RAW_W+COORD_BITS:0]  numerator,
    input  wire logic [tecs_pkg::RAW_W-1:0]           divisor,
    output logic                                      done,
    output logic [COORD_BITS-1:0]                     quotient
);

    localparam int RW    = tecs_pkg::RAW_W;
    localparam int CNT_W = $clog2(COORD_BITS + 1);

    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         den_reg;
    logic [COORD_BITS-1:0] low_reg, low_next;
    logic [COORD_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RW:0]           shifted;
    logic [RW:0]           diff;
    logic                  fits;

    always_comb
    begin
        shifted = {rem_reg, low_reg[COORD_BITS-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});
    end

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = numerator[COORD_BITS +: RW];
            low_next  = numerator[COORD_BITS-1:0];
            quo_next  = '0;
            cnt_next  = CNT_W'(COORD_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[RW-1:0] : shifted[RW-1:0];
            low_next = {low_reg[COORD_BITS-2:0], 1'b0};
            quo_next = {quo_reg[COORD_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[rtl/core/touch_event_coordinate_scaler_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Touch event coordinate scaler.
// Input events arrive on the events channel (valid/ready, type, code, signed
// value); scaled points leave on the points channel; six range and screen
// registers are written through cfg_wr_en / cfg_index / cfg_wdata. They are
// to be written only while idle; the block itself does not enforce this.
// Key events, ignored events and axis events whose reading lies outside the
// raw window are settled as they are taken. A reading inside the window
// runs through a bit-serial multiplier (one raw bit per cycle) and then a
// bit-serial divider (one quotient bit per cycle), after which the result is
// written to the held point; no further request is taken until the divide is
// done. A sync event that finds a pending coordinate loads its point into the
// output register, or waits in the emit state while that register still
// holds a point that the receiver has not taken.
// Reset clears the held point and the pending mark and loads the default
// window of 240 by 320 pixels. When the receiver stalls, the output register
// holds its point and the block keeps taking events; only a second point
// behind the waiting one makes the block hold back further requests.
module touch_event_coordinate_scaler_core #(
    parameter int COORD_BITS = tecs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    tecs_event_if.sink                               events,
    tecs_point_if.source                             points,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tecs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tecs_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int RW     = tecs_pkg::RAW_W;
    localparam int SIZE_W = COORD_BITS + 1;
    localparam int CMP_W  = (SIZE_W > tecs_pkg::SIZE_CFG_W) ? SIZE_W : tecs_pkg::SIZE_CFG_W;
    localparam int PROD_W = RW + COORD_BITS + 1;

    // Configuration registers.
    logic [RW-1:0]                  x_raw_low_reg, x_raw_high_reg;
    logic [RW-1:0]                  y_raw_low_reg, y_raw_high_reg;
    logic [tecs_pkg::SIZE_CFG_W-1:0] screen_width_reg, screen_height_reg;

    // Held coordinate state.
    logic [COORD_BITS-1:0] held_x_reg, held_x_next;
    logic [COORD_BITS-1:0] held_y_reg, held_y_next;
    logic                  seen_reg, seen_next;

    // Context of the axis reading that is being scaled.
    logic                  axis_y_reg;
    logic [COORD_BITS-1:0] size_m1_reg;

    // Output register.
    logic                       out_valid_reg, out_valid_next;
    logic [tecs_pkg::OUT_W-1:0] out_x_reg, out_y_reg;

    tecs_pkg::tecs_state_t state_reg, state_next;

    // Decode of the presented request.
    logic                      accept;
    logic                      is_sync, is_touch_key, is_axis, is_axis_y;
    logic [RW-1:0]             sel_low, sel_high;
    logic [tecs_pkg::SIZE_CFG_W-1:0] sel_size_cfg;
    logic [CMP_W-1:0]          size_ext, size_lim;
    logic [SIZE_W-1:0]         eff_size;
    logic [COORD_BITS-1:0]     eff_size_m1;
    logic                      value_neg, value_wide, below, at_or_above, in_window;
    logic [RW-1:0]             raw_offset;
    logic [RW-1:0]             raw_span;
    logic                      out_free;

    // Control outputs of the state machine.
    logic mul_start, div_start, load_out;

    logic                  mul_done, div_done;
    logic [PROD_W-1:0]     product;
    logic [COORD_BITS-1:0] quotient;

    assign accept   = events.valid && events.ready;
    assign out_free = !out_valid_reg || points.ready;

    always_comb
    begin
        is_sync      = (events.event_type == tecs_pkg::EV_SYNC);
        is_touch_key = (events.event_type == tecs_pkg::EV_KEY)
                    && (events.event_code == tecs_pkg::KEY_TOUCH);
        is_axis_y    = (events.event_code == tecs_pkg::AXIS_Y);
        is_axis      = (events.event_type == tecs_pkg::EV_ABS)
                    && (is_axis_y || (events.event_code == tecs_pkg::AXIS_X));

        sel_low      = is_axis_y ? y_raw_low_reg     : x_raw_low_reg;
        sel_high     = is_axis_y ? y_raw_high_reg    : x_raw_high_reg;
        sel_size_cfg = is_axis_y ? screen_height_reg : screen_width_reg;

        // A zero size counts as one pixel; a size beyond the coordinate
        // range is limited to a full range of columns or rows.
        size_ext = CMP_W'(sel_size_cfg);
        size_lim = CMP_W'(1) << COORD_BITS;
        if (size_ext == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (size_ext > size_lim)
        begin
            eff_size = SIZE_W'(size_lim);
        end
        else
        begin
            eff_size = SIZE_W'(size_ext);
        end
        eff_size_m1 = COORD_BITS'(eff_size - SIZE_W'(1));

        // Window tests on the signed 32-bit reading against 16-bit limits.
        value_neg   = events.event_value[tecs_pkg::VALUE_W-1];
        value_wide  = |events.event_value[tecs_pkg::VALUE_W-2:RW];
        below       = value_neg || (!value_wide && (events.event_value[RW-1:0] < sel_low));
        at_or_above = !below && (value_wide || (events.event_value[RW-1:0] >= sel_high));
        in_window   = !below && !at_or_above;

        raw_offset = events.event_value[RW-1:0] - sel_low;
        raw_span   = sel_high - sel_low;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tecs_pkg::ST_IDLE:
            begin
                if (accept && is_sync && seen_reg && !out_free)
                begin
                    state_next = tecs_pkg::ST_EMIT;
                end
                else if (accept && is_axis && in_window)
                begin
                    state_next = tecs_pkg::ST_MUL;
                end
            end
            tecs_pkg::ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = tecs_pkg::ST_DIV;
                end
            end
            tecs_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = tecs_pkg::ST_IDLE;
                end
            end
            tecs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tecs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tecs_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        events.ready = 1'b0;
        mul_start    = 1'b0;
        div_start    = 1'b0;
        load_out     = 1'b0;
        case (state_reg)
            tecs_pkg::ST_IDLE:
            begin
                events.ready = 1'b1;
                mul_start    = accept && is_axis && in_window;
                load_out     = accept && is_sync && seen_reg && out_free;
            end
            tecs_pkg::ST_MUL:
            begin
                div_start = mul_done;
            end
            tecs_pkg::ST_DIV:
            begin
                div_start = 1'b0;
            end
            tecs_pkg::ST_EMIT:
            begin
                load_out = out_free;
            end
            default:
            begin
                events.ready = 1'b0;
            end
        endcase
    end

    // Held point and pending mark.
    always_comb
    begin
        held_x_next = held_x_reg;
        held_y_next = held_y_reg;
        seen_next   = seen_reg;
        if (state_reg == tecs_pkg::ST_IDLE && accept)
        begin
            if (is_touch_key)
            begin
                held_x_next = '0;
                held_y_next = '0;
                seen_next   = 1'b0;
            end
            else if (is_axis)
            begin
                seen_next = 1'b1;
                // Readings outside the window are settled at once; the Y axis
                // counts rows from the top, so its ends are swapped.
                if (below)
                begin
                    if (is_axis_y)
                    begin
                        held_y_next = eff_size_m1;
                    end
                    else
                    begin
                        held_x_next = '0;
                    end
                end
                else if (at_or_above)
                begin
                    if (is_axis_y)
                    begin
                        held_y_next = '0;
                    end
                    else
                    begin
                        held_x_next = eff_size_m1;
                    end
                end
            end
        end
        else if (state_reg == tecs_pkg::ST_DIV && div_done)
        begin
            if (axis_y_reg)
            begin
                held_y_next = size_m1_reg - quotient;
            end
            else
            begin
                held_x_next = quotient;
            end
        end
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (points.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tecs_pkg::ST_IDLE;
            held_x_reg        <= '0;
            held_y_reg        <= '0;
            seen_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
            x_raw_low_reg     <= tecs_pkg::X_RAW_LOW_RST;
            x_raw_high_reg    <= tecs_pkg::X_RAW_HIGH_RST;
            y_raw_low_reg     <= tecs_pkg::Y_RAW_LOW_RST;
            y_raw_high_reg    <= tecs_pkg::Y_RAW_HIGH_RST;
            screen_width_reg  <= tecs_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= tecs_pkg::SCREEN_HEIGHT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    tecs_pkg::CFG_X_RAW_LOW:     x_raw_low_reg  <= cfg_wdata;
                    tecs_pkg::CFG_X_RAW_HIGH:    x_raw_high_reg <= cfg_wdata;
                    tecs_pkg::CFG_Y_RAW_LOW:     y_raw_low_reg  <= cfg_wdata;
                    tecs_pkg::CFG_Y_RAW_HIGH:    y_raw_high_reg <= cfg_wdata;
                    tecs_pkg::CFG_SCREEN_WIDTH:
                        screen_width_reg  <= cfg_wdata[tecs_pkg::SIZE_CFG_W-1:0];
                    tecs_pkg::CFG_SCREEN_HEIGHT:
                        screen_height_reg <= cfg_wdata[tecs_pkg::SIZE_CFG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            axis_y_reg  <= is_axis_y;
            size_m1_reg <= eff_size_m1;
        end
        if (load_out)
        begin
            out_x_reg <= tecs_pkg::OUT_W'(held_x_reg);
            out_y_reg <= tecs_pkg::OUT_W'(held_y_reg);
        end
    end

    assign points.valid   = out_valid_reg;
    assign points.point_x = out_x_reg;
    assign points.point_y = out_y_reg;

    // Offset times screen size, one raw bit per cycle.
    tecs_serial_mul #(
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (eff_size),
        .multiplier   (raw_offset),
        .done         (mul_done),
        .product      (product)
    );

    // The divisor is captured at the start of the multiply and held until
    // the divide begins.
    logic [RW-1:0] span_reg;

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            span_reg <= raw_span;
        end
    end

    // Product over raw span, one quotient bit per cycle.
    tecs_serial_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .numerator (product),
        .divisor   (span_reg),
        .done      (div_done),
        .quotient  (quotient)
    );

endmodule

`default_nettype wire
